@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HNS_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`define HNS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`else
`define HNS_ASSERT_NEVER(lbl, clk, rstn, cond)
`define HNS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/hns_pkg.sv @@
// ---------------------------------------------------------------------------
// hns_pkg
// types and constants of the heightmap normal and slope block
// ---------------------------------------------------------------------------
`default_nettype none
package hns_pkg;
    localparam int GW_W   = 9;
    localparam int GAIN_W = 16;
    localparam int CELL_W = 16;
    localparam int H_W    = 16;
    localparam int MIN_GRID = 5;
    localparam logic [15:0] SLOPE_BIAS = 16'd16416;
    localparam logic [14:0] Q_ONE = 15'd16384;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_HEIGHT_GAIN = 2'd1,
        CFG_CELL_SIZE   = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        F_IDLE,
        F_READ
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_NORM,
        B_SQ,
        B_SQRT,
        B_DIVI,
        B_DIV,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [7:0]         vx;
        logic [7:0]         vy;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [7:0]         slope;
        logic [14:0]        nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
        logic [7:0]         vy;
        logic [7:0]         vx;
    } result_t;
endpackage
`default_nettype wire

@@ rtl/core/hns_ram.sv @@
// ---------------------------------------------------------------------------
// hns_ram
// single port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none
module hns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/hns_front.sv @@
// ---------------------------------------------------------------------------
// hns_front
// raster counters, row store and window, difference terms per vertex
// ---------------------------------------------------------------------------
`default_nettype none
module hns_front #(
    parameter int MAX_GRID_WIDTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [hns_pkg::GW_W-1:0]      grid_width,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hns_pkg::H_W-1:0]       s_tdata,
    input  wire logic                          s_tuser,
    output logic                               q_push,
    output hns_pkg::job_t                      q_job,
    input  wire logic                          q_full
);
    localparam int CW = $clog2(MAX_GRID_WIDTH);
    localparam int WW = CW + 1;
    localparam int LW = (WW > hns_pkg::GW_W) ? WW : hns_pkg::GW_W;
    localparam logic [LW-1:0] WMAX = LW'(MAX_GRID_WIDTH);
    localparam logic [LW-1:0] WMIN = LW'(hns_pkg::MIN_GRID);

    hns_pkg::front_state_t state_reg, state_next;
    logic [CW-1:0] col_reg, row_reg, cur_c_reg, cur_r_reg, ram_addr;
    logic [15:0] sample_reg, prev_reg, win0_reg, win1_reg, win2_reg, up, upup;
    logic [31:0] ram_q;
    logic [LW-1:0] gw, w, col_a, row_a, nc, nr;
    logic emit, done_read, accept;

    always_comb begin
        gw = LW'(grid_width);
        w = (gw < WMIN) ? WMIN : ((gw > WMAX) ? WMAX : gw);
        col_a = LW'(col_reg);
        row_a = LW'(row_reg);
        if (s_tuser) begin
            col_a = '0;
            row_a = '0;
        end
        if (col_a >= w) begin
            col_a = '0;
            row_a = row_a + LW'(1);
        end
        if (row_a >= w) begin
            row_a = '0;
        end
        nc = col_a + LW'(1);
        nr = row_a;
        if (nc >= w) begin
            nc = '0;
            nr = row_a + LW'(1);
            if (nr >= w) begin
                nr = '0;
            end
        end
    end

    assign up   = ram_q[15:0];
    assign upup = ram_q[31:16];
    assign emit = (cur_r_reg >= CW'(2)) && (cur_c_reg >= CW'(2));

    // outputs
    always_comb begin
        s_tready  = (state_reg == hns_pkg::F_IDLE);
        accept    = s_tready && s_tvalid;
        done_read = (state_reg == hns_pkg::F_READ) && !(emit && q_full);
        q_push    = (state_reg == hns_pkg::F_READ) && emit && !q_full;
        ram_addr  = (state_reg == hns_pkg::F_IDLE) ? col_a[CW-1:0] : cur_c_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hns_pkg::F_IDLE: begin
                if (s_tvalid) begin
                    state_next = hns_pkg::F_READ;
                end
            end
            hns_pkg::F_READ: begin
                if (done_read) begin
                    state_next = hns_pkg::F_IDLE;
                end
            end
            default: state_next = hns_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        q_job.dx   = {win1_reg[15], win1_reg} - {up[15], up};
        q_job.dy   = {win2_reg[15], win2_reg} - {prev_reg[15], prev_reg};
        q_job.vx   = 8'(32'(cur_c_reg) - 32'd2);
        q_job.vy   = 8'(32'(cur_r_reg) - 32'd2);
        q_job.last = (LW'(cur_c_reg) == w - LW'(1)) && (LW'(cur_r_reg) == w - LW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hns_pkg::F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win0_reg  <= '0;
            win1_reg  <= '0;
            win2_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                col_reg <= nc[CW-1:0];
                row_reg <= nr[CW-1:0];
            end
            if (done_read) begin
                win1_reg <= win0_reg;
                win0_reg <= up;
                win2_reg <= upup;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_c_reg  <= col_a[CW-1:0];
            cur_r_reg  <= row_a[CW-1:0];
            sample_reg <= s_tdata;
        end
        if (done_read) begin
            prev_reg <= sample_reg;
        end
    end

    hns_ram #(
        .WIDTH (32),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (done_read),
        .addr  (ram_addr),
        .wdata ({up, sample_reg}),
        .rdata (ram_q)
    );
endmodule
`default_nettype wire

@@ rtl/core/hns_queue.sv @@
// ---------------------------------------------------------------------------
// hns_queue
// two entry queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hns_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire hns_pkg::job_t  push_job,
    output logic                full,
    input  wire logic           pop,
    output hns_pkg::job_t       pop_job,
    output logic                empty
);
    hns_pkg::job_t entry_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `HNS_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && full)
    `HNS_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && empty)
    `HNS_ASSERT_NEVER(a_count_range, aclk, aresetn, count_reg == 2'd3)
endmodule
`default_nettype wire

@@ rtl/core/hns_back.sv @@
// ---------------------------------------------------------------------------
// hns_back
// scaling, normalize, square root and division for one vertex normal
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hns_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [hns_pkg::GAIN_W-1:0]  height_gain,
    input  wire logic [hns_pkg::CELL_W-1:0]  cell_size,
    input  wire logic                        q_empty,
    input  wire hns_pkg::job_t               q_job,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output hns_pkg::result_t                 m_data,
    output logic                             m_last
);
    hns_pkg::back_state_t state_reg, state_next;
    hns_pkg::job_t job_reg;
    logic [33:0] a_reg [3];
    logic [14:0] nq_reg [3];
    logic [4:0]  step_reg;
    logic [1:0]  comp_reg, a_idx;
    logic [63:0] acc_reg, bit_reg, res_reg, rb, res_n;
    logic [31:0] len_reg;
    logic [46:0] rem_reg, dsh_reg;
    logic [14:0] q_reg, q_n;
    logic zero_reg, valid_reg, out_load, div_ge, sq_ge;
    logic [33:0] m, a_sel;
    logic [16:0] abs_x, abs_y;
    logic [32:0] px, py;
    logic [61:0] sq;
    logic signed [15:0] nxs, nys;
    logic [15:0] sl_t;
    hns_pkg::result_t res_d;
    hns_pkg::result_t data_reg;
    logic last_reg;

    always_comb begin
        a_idx = (state_reg == hns_pkg::B_SQ) ? step_reg[1:0] : comp_reg;
        a_sel = a_reg[a_idx];
        m = a_reg[0];
        if (a_reg[1] > m) begin
            m = a_reg[1];
        end
        if (a_reg[2] > m) begin
            m = a_reg[2];
        end
        abs_x = job_reg.dx[16] ? 17'(-job_reg.dx) : 17'(job_reg.dx);
        abs_y = job_reg.dy[16] ? 17'(-job_reg.dy) : 17'(job_reg.dy);
        px = abs_x * height_gain;
        py = abs_y * height_gain;
        sq = a_sel[30:0] * a_sel[30:0];
        rb = res_reg + bit_reg;
        sq_ge = (acc_reg >= rb);
        res_n = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        div_ge = (rem_reg >= dsh_reg);
        q_n = {q_reg[13:0], div_ge};
        nxs = 16'(nq_reg[0]);
        nys = 16'(nq_reg[1]);
        sl_t = hns_pkg::SLOPE_BIAS - {1'b0, nq_reg[2]};
        res_d.vx = job_reg.vx;
        res_d.vy = job_reg.vy;
        if (zero_reg) begin
            res_d.nx = '0;
            res_d.ny = '0;
            res_d.nz = '0;
            res_d.slope = 8'd255;
        end else begin
            res_d.nx = job_reg.dx[16] ? -nxs : nxs;
            res_d.ny = job_reg.dy[16] ? -nys : nys;
            res_d.nz = nq_reg[2];
            res_d.slope = (sl_t[15:6] > 10'd255) ? 8'd255 : sl_t[13:6];
        end
    end

    // outputs
    always_comb begin
        q_pop    = (state_reg == hns_pkg::B_IDLE) && !q_empty;
        out_load = (state_reg == hns_pkg::B_OUT) && (!valid_reg || m_ready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hns_pkg::B_IDLE: if (!q_empty) state_next = hns_pkg::B_MUL;
            hns_pkg::B_MUL:  state_next = hns_pkg::B_NORM;
            hns_pkg::B_NORM: begin
                if (m == '0) begin
                    state_next = hns_pkg::B_OUT;
                end else if (m[33:31] == 3'd0 && m[30]) begin
                    state_next = hns_pkg::B_SQ;
                end
            end
            hns_pkg::B_SQ:   if (step_reg == 5'd2) state_next = hns_pkg::B_SQRT;
            hns_pkg::B_SQRT: if (step_reg == 5'd0) state_next = hns_pkg::B_DIVI;
            hns_pkg::B_DIVI: state_next = hns_pkg::B_DIV;
            hns_pkg::B_DIV: begin
                if (step_reg == 5'd0) begin
                    state_next = (comp_reg == 2'd2) ? hns_pkg::B_OUT : hns_pkg::B_DIVI;
                end
            end
            hns_pkg::B_OUT:  if (out_load) state_next = hns_pkg::B_IDLE;
            default:         state_next = hns_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hns_pkg::B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            hns_pkg::B_IDLE: begin
                job_reg <= q_job;
            end
            hns_pkg::B_MUL: begin
                a_reg[0] <= 34'(px);
                a_reg[1] <= 34'(py);
                a_reg[2] <= {9'd0, cell_size, 9'd0};
                zero_reg <= 1'b0;
            end
            hns_pkg::B_NORM: begin
                if (m == '0) begin
                    zero_reg <= 1'b1;
                end else if (m[33:31] != 3'd0) begin
                    a_reg[0] <= a_reg[0] >> 1;
                    a_reg[1] <= a_reg[1] >> 1;
                    a_reg[2] <= a_reg[2] >> 1;
                end else if (!m[30]) begin
                    a_reg[0] <= a_reg[0] << 1;
                    a_reg[1] <= a_reg[1] << 1;
                    a_reg[2] <= a_reg[2] << 1;
                end else begin
                    acc_reg  <= '0;
                    step_reg <= 5'd0;
                end
            end
            hns_pkg::B_SQ: begin
                acc_reg <= acc_reg + 64'(sq);
                if (step_reg == 5'd2) begin
                    bit_reg  <= 64'd1 << 62;
                    res_reg  <= '0;
                    step_reg <= 5'd31;
                end else begin
                    step_reg <= step_reg + 5'd1;
                end
            end
            hns_pkg::B_SQRT: begin
                if (sq_ge) begin
                    acc_reg <= acc_reg - rb;
                end
                res_reg  <= res_n;
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0) begin
                    len_reg  <= res_n[31:0];
                    comp_reg <= 2'd0;
                end
            end
            hns_pkg::B_DIVI: begin
                rem_reg  <= {2'b0, a_sel[30:0], 14'd0} + 47'(len_reg >> 1);
                dsh_reg  <= {1'b0, len_reg, 14'd0};
                q_reg    <= '0;
                step_reg <= 5'd14;
            end
            hns_pkg::B_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg    <= q_n;
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0) begin
                    nq_reg[comp_reg] <= q_n;
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            hns_pkg::B_OUT: begin
                if (out_load) begin
                    data_reg <= res_d;
                    last_reg <= job_reg.last;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign m_last  = last_reg;

    `HNS_ASSERT_IMPLY(a_len_nonzero, aclk, aresetn, state_reg == hns_pkg::B_DIV, len_reg != '0)
    `HNS_ASSERT_IMPLY(a_nz_range, aclk, aresetn, valid_reg, data_reg.nz <= hns_pkg::Q_ONE)
    `HNS_ASSERT_IMPLY(a_flat_slope, aclk, aresetn, valid_reg && data_reg.nz == '0,
        data_reg.slope == 8'd255)
endmodule
`default_nettype wire

@@ rtl/core/heightmap_normal_slope.sv @@
// a vertex result passes the front, the two entry queue and the back unit, whose output is registered
// the front takes one sample at a time: it reads the row memory, then writes it back
// the shared back unit works on one vertex at a time through n normalize shifts (0 to 30),
// the bit-serial square root (32 steps) and three 15-step divisions; a full queue stalls the front
// reset: synchronous active low, clears counters, window, queue and control;
// row memory is not cleared
// ---------------------------------------------------------------------------
// heightmap_normal_slope
// central difference surface normal and slope byte over a streamed height grid
// ---------------------------------------------------------------------------
`default_nettype none
module heightmap_normal_slope #(
    parameter int MAX_GRID_WIDTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // height_sample
    input  wire logic        s_tuser,   // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // vertex_x, vertex_y, normal_x, normal_y, normal_z, slope_level
    output logic             m_tlast
);
    logic [hns_pkg::GW_W-1:0]   grid_width_reg;
    logic [hns_pkg::GAIN_W-1:0] height_gain_reg;
    logic [hns_pkg::CELL_W-1:0] cell_size_reg;
    logic q_push, q_full, q_pop, q_empty;
    hns_pkg::job_t push_job, pop_job;
    hns_pkg::result_t m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd67;
            height_gain_reg <= 16'd256;
            cell_size_reg   <= 16'd100;
        end else if (cfg_we) begin
            case (cfg_addr)
                hns_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[8:0];
                hns_pkg::CFG_HEIGHT_GAIN: height_gain_reg <= cfg_wdata;
                hns_pkg::CFG_CELL_SIZE:   cell_size_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    hns_front #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .grid_width (grid_width_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_push     (q_push),
        .q_job      (push_job),
        .q_full     (q_full)
    );

    hns_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    hns_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .height_gain (height_gain_reg),
        .cell_size   (cell_size_reg),
        .q_empty     (q_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_data      (m_data),
        .m_last      (m_tlast)
    );

    assign m_tdata = {1'b0, m_data};
endmodule
`default_nettype wire
